/* sv/per_pixel_spectrum_histogram_defines.svh */
// Assertion macros used by the per-pixel spectrum histogram controller.
`ifndef PER_PIXEL_SPECTRUM_HISTOGRAM_DEFINES_SVH
`define PER_PIXEL_SPECTRUM_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pph_pkg.sv */
// Shared constants, types and command structs of the per-pixel spectrum histogram.
`timescale 1ns / 1ps

package pph_pkg;

  localparam int PIXELS   = 1024;
  localparam int MAX_BINS = 128;
  localparam int DEPTH    = PIXELS * MAX_BINS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int PADDR_W  = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_AMP_MIN   = 2'd0;
  localparam logic [1:0] REG_BIN_SCALE = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT = 2'd2;

  localparam logic        OP_ACCUMULATE = 1'b0;
  localparam logic        OP_READ       = 1'b1;

  localparam logic signed [15:0] AMP_MIN_RESET   = 16'sd0;
  localparam logic [23:0]        BIN_SCALE_RESET = 24'd6554;
  localparam logic [7:0]         BIN_COUNT_RESET = 8'd100;

  typedef struct packed {
    logic signed [15:0] amp_min;
    logic [23:0]        bin_scale;
    logic [7:0]         bin_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;   // write zero at the clear pointer and advance it
    logic load;  // capture the incoming word
    logic mul;   // register the scaled amplitude product
    logic addr;  // register the store address and range flags
    logic rd;    // read the store at the registered address
    logic wr;    // write back the incremented count
    logic resp;  // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic out_hold;
  } stat_t;

endpackage

/* sv/per_pixel_spectrum_histogram.sv */
// Top level of the per-pixel spectrum histogram: registers, controller and datapath.
`timescale 1ns / 1ps

// The block keeps one 32-bit amplitude histogram of 128 bins for each of 1024
// pixels in a single-port-write, registered-read store of 131072 words. After
// reset it first runs a clearing pass that writes zero to every word, one word
// a cycle, so input words are refused until the pass ends; configuration writes
// are taken during that pass as at any other time. An input word is then
// handled one at a time, in these steps from its acceptance to the next
// acceptance: capture, the amplitude-by-scale multiply, address formation,
// the store read, and either the saturating write-back for an accumulate or
// the load of the output register for a read. These steps follow the
// read-modify-write through the single store port. A read result sits in an
// output register, so the next word is taken while it waits; a second read
// waits in its last step until the output register is free. Configuration
// must only be written while no word is in flight.

module per_pixel_spectrum_histogram (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pph_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [9:0]                   pixel,
  input  logic signed [15:0]           amplitude,
  input  logic [6:0]                   read_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  bin_value,
  output logic [9:0]                   out_pixel,
  output logic [6:0]                   out_bin
);
  import pph_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Register file: amp_min, bin_scale and bin_count at byte addresses 0, 4, 8.
  pph_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller sequences the clearing pass and each word's steps.
  pph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the captured word, the bin mapping, the count store
  // and the output register.
  pph_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .op        (op),
    .pixel     (pixel),
    .amplitude (amplitude),
    .read_bin  (read_bin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_value (bin_value),
    .out_pixel (out_pixel),
    .out_bin   (out_bin)
  );

endmodule

/* sv/pph_regs.sv */
// APB configuration registers of the per-pixel spectrum histogram.
`timescale 1ns / 1ps

module pph_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [pph_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output pph_pkg::cfg_t          cfg
);
  import pph_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_min   <= AMP_MIN_RESET;
      cfg.bin_scale <= BIN_SCALE_RESET;
      cfg.bin_count <= BIN_COUNT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_AMP_MIN:   cfg.amp_min   <= signed'(pwdata[15:0]);
        REG_BIN_SCALE: cfg.bin_scale <= pwdata[23:0];
        REG_BIN_COUNT: cfg.bin_count <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_AMP_MIN:   prdata = {16'd0, cfg.amp_min};
      REG_BIN_SCALE: prdata = {8'd0, cfg.bin_scale};
      REG_BIN_COUNT: prdata = {24'd0, cfg.bin_count};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* sv/pph_datapath.sv */
// Datapath of the per-pixel spectrum histogram: bin mapping, count store and output register.
`timescale 1ns / 1ps

module pph_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pph_pkg::cmd_t      cmd,
  output pph_pkg::stat_t     stat,
  input  pph_pkg::cfg_t      cfg,
  input  logic               op,
  input  logic [9:0]         pixel,
  input  logic signed [15:0] amplitude,
  input  logic [6:0]         read_bin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        bin_value,
  output logic [9:0]         out_pixel,
  output logic [6:0]         out_bin
);
  import pph_pkg::*;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata;

  logic               op_q;
  logic [9:0]         pixel_q;
  logic signed [15:0] amp_q;
  logic [6:0]         rbin_q;

  logic signed [16:0] diff;
  logic               neg_q;
  logic [39:0]        prod_q;

  logic [BIN_W-1:0]   last_bin;
  logic [BIN_W-1:0]   acc_bin;
  logic [BIN_W-1:0]   sel_bin;
  logic               pix_ok;
  logic               rbin_ok;
  logic [ADDR_W-1:0]  addr_q;
  logic               pix_ok_q;
  logic               rbin_ok_q;

  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [31:0]        wr_data;
  logic               wr_en;
  logic [31:0]        count_inc;

  assign diff = 17'(amp_q) - 17'(cfg.amp_min);

  // Highest bin in use: a zero count means one bin, a large one is capped.
  always_comb begin
    if (cfg.bin_count == 8'd0) begin
      last_bin = '0;
    end else if (32'(cfg.bin_count) > MAX_BINS) begin
      last_bin = BIN_W'(MAX_BINS - 1);
    end else begin
      last_bin = BIN_W'(cfg.bin_count - 8'd1);
    end
  end

  always_comb begin
    if (neg_q) begin
      acc_bin = '0;
    end else if (32'(prod_q[39:16]) > 32'(last_bin)) begin
      acc_bin = last_bin;
    end else begin
      acc_bin = BIN_W'(prod_q[39:16]);
    end
  end

  assign pix_ok  = 32'(pixel_q) < PIXELS;
  assign rbin_ok = 32'(rbin_q) < MAX_BINS;
  assign sel_bin = (op_q == OP_READ) ? BIN_W'(rbin_q) : acc_bin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      pixel_q <= pixel;
      amp_q   <= amplitude;
      rbin_q  <= read_bin;
    end
    if (cmd.mul) begin
      neg_q  <= diff[16];
      prod_q <= 40'(diff[15:0]) * 40'(cfg.bin_scale);
    end
    if (cmd.addr) begin
      addr_q    <= ADDR_W'(32'(pixel_q) * MAX_BINS + 32'(sel_bin));
      pix_ok_q  <= pix_ok;
      rbin_ok_q <= rbin_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign count_inc = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
  assign wr_en     = cmd.clr | (cmd.wr & pix_ok_q);
  assign wr_addr   = cmd.clr ? clr_addr : addr_q;
  assign wr_data   = cmd.clr ? 32'd0 : count_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      bin_value <= (pix_ok_q & rbin_ok_q) ? rdata : 32'd0;
      out_pixel <= pixel_q;
      out_bin   <= rbin_q;
    end
  end

  assign stat.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.is_read  = (op_q == OP_READ);
  assign stat.out_hold = out_valid & ~out_ready;

endmodule

/* sv/pph_ctrl.sv */
// Controller state machine of the per-pixel spectrum histogram.
`timescale 1ns / 1ps
`include "per_pixel_spectrum_histogram_defines.svh"

module pph_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pph_pkg::stat_t stat,
  output pph_pkg::cmd_t  cmd
);
  import pph_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.is_read) begin
          cmd.wr     = 1'b1;
          state_next = S_IDLE;
        end else if (!stat.out_hold) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  `PPH_ASSERT_NOW(a_ready_idle, in_ready, state == S_IDLE, "ready outside idle")
  `PPH_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_MUL && !in_ready,
                   "accepted word did not start")
  `PPH_ASSERT_NEXT(a_clear_holds, state == S_CLEAR && !stat.clr_last, state == S_CLEAR,
                   "clear pass ended early")
  `PPH_ASSERT_NEXT(a_resp_waits, state == S_DONE && stat.is_read && stat.out_hold,
                   state == S_DONE, "read result dropped while output full")

endmodule
